[rtl/nbg_pkg.sv]
// Package: shared types and constants for the n-body gravity step block.
package nbg_pkg;

  localparam int unsigned BodyW = 160;   // mass, pos x, pos y, vel x, vel y

  localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [1:0] CFG_GRAVITY   = 2'd1;
  localparam logic [1:0] CFG_STAR_CNT  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [33:0] F_CAP = 34'h2_0000_0000;

  typedef struct packed {
    logic [31:0] mass;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } body_t;

  // iterative divider control
  typedef struct packed {
    logic        start;
    logic        busy;
    logic        done;
  } div_ctl_t;

  function automatic logic signed [63:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = 64'sd2147483647;
    end else if (v < -66'sd2147483648) begin
      sat32 = -64'sd2147483648;
    end else begin
      sat32 = v[63:0];
    end
  endfunction

endpackage

[rtl/nbg_ram.sv]
// Generic single-port RAM with registered read.
module nbg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/nbg_div.sv]
// Restoring bit-serial divider: quotient of num by den, one bit per cycle.
module nbg_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [79:0]  num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [79:0]  quot
);

  logic [79:0] n_sh;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem[63:0], n_sh[79]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        rem  <= '0;
        n_sh <= num;
        quot <= '0;
      end else if (busy) begin
        n_sh <= {n_sh[78:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem  <= trial - {1'b0, den};
          quot <= {quot[78:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[78:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd79) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/nbody_gravity_euler_step.sv]
// Top level: n-body gravity, semi-implicit Euler step, body table in RAM.
// The body table (mass, position, velocity, Q16.16) sits in one RAM with a
// registered read; a new-velocity RAM holds phase-one results so old
// positions stay intact until phase two. A load item writes one entry.
// A step item walks all N*(N-1) ordered pairs; each pair runs a bit-serial
// square root and three bit-serial divides through one shared divider (a
// coincident pair skips the divides), and the output can stall a step.
// Results come out one per body in index order from an output register;
// the block takes no new item until the last result of a step is taken.
// Multiplies are at most 34x32.
module nbody_gravity_euler_step #(
  parameter int unsigned MAX_STARS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [2:0]         body_index,
  input  logic [31:0]        mass_in,
  input  logic signed [31:0] pos_x_in,
  input  logic signed [31:0] pos_y_in,
  input  logic signed [31:0] vel_x_in,
  input  logic signed [31:0] vel_y_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         body_out,
  output logic signed [31:0] pos_x_out,
  output logic signed [31:0] pos_y_out,
  output logic signed [31:0] vel_x_out,
  output logic signed [31:0] vel_y_out,
  output logic               last_body
);

  localparam int unsigned AW = $clog2(MAX_STARS);
  localparam int unsigned CW = $clog2(MAX_STARS + 1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_RDI  = 16'h0002, S_RDJ   = 16'h0004,
    S_DIFF  = 16'h0008, S_SQ   = 16'h0010, S_SQRT  = 16'h0020,
    S_FDIV  = 16'h0040, S_UXD  = 16'h0080, S_UYD   = 16'h0100,
    S_TERM  = 16'h0200, S_NXTJ = 16'h0400, S_VEL   = 16'h0800,
    S_PRD   = 16'h1000, S_POS  = 16'h2000, S_OUT   = 16'h4000,
    S_VEL2  = 16'h8000
  } state_t;

  state_t state;

  logic [31:0] step_size, gravity_constant;
  logic [3:0]  star_count;
  logic [CW-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= 32'd65536;
      gravity_constant <= 32'd65536;
      star_count       <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        nbg_pkg::CFG_STEP_SIZE: step_size        <= cfg_data;
        nbg_pkg::CFG_GRAVITY:   gravity_constant <= cfg_data;
        nbg_pkg::CFG_STAR_CNT:  star_count       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({28'd0, star_count} > MAX_STARS) n_eff = CW'(MAX_STARS);
    else n_eff = CW'(star_count);
  end

  // body table and new-velocity table
  logic           b_we;
  logic [AW-1:0]  b_addr;
  nbg_pkg::body_t b_wdata, b_rdata;
  logic           v_we;
  logic [AW-1:0]  v_addr;
  logic [63:0]    v_wdata, v_rdata;

  nbg_ram #(.WIDTH(nbg_pkg::BodyW), .DEPTH(MAX_STARS)) u_body (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata));
  nbg_ram #(.WIDTH(64), .DEPTH(MAX_STARS)) u_vel (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));

  // shared divider
  logic        d_start, d_done;
  logic [79:0] d_num, d_quot;
  logic [63:0] d_den;
  nbg_div u_div (.clk(clk), .rst(rst), .start(d_start), .num(d_num),
                 .den(d_den), .done(d_done), .quot(d_quot));

  logic [AW-1:0] ii, jj;
  logic signed [31:0] xi, yi, vxi, vyi;
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [65:0] sqx, sqy;
  logic [63:0] sqv, sq_rem;
  logic [31:0] rh, sq_res;
  logic [5:0]  sq_cnt;
  logic [47:0] k;
  logic [33:0] f;
  logic [63:0] ux;
  logic signed [67:0] ax, ay;
  logic signed [63:0] mtmp, sx_sat, sy_sat;
  logic [97:0] prod;
  logic        div_go;
  logic        phase2;

  // bit-serial integer square root step
  logic [65:0] sq_trial;
  assign sq_trial = {sq_rem[63:0], sqv[63:62]};

  // (a * b) >> 16 rounded toward zero; a is a saturated 32-bit value
  function automatic logic signed [63:0] mulq(input logic signed [31:0] a,
                                              input logic [31:0] b);
    logic [31:0] m;
    logic [63:0] p;
    m = a[31] ? 32'(-a) : 32'(a);
    p = {32'd0, m} * {32'd0, b};
    mulq = a[31] ? -64'(p[63:16]) : 64'(p[63:16]);
  endfunction

  assign d_start = div_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_go    <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready && opcode == nbg_pkg::OP_STEP && n_eff != '0) begin
            ii <= '0; jj <= '0; ax <= '0; ay <= '0; phase2 <= 1'b0;
            state <= S_RDI;
          end
        end
        S_RDI: state <= S_RDJ;
        S_RDJ: begin
          if (!phase2) begin
            xi <= b_rdata.pos_x; yi <= b_rdata.pos_y;
            vxi <= b_rdata.vel_x; vyi <= b_rdata.vel_y;
            state <= S_DIFF;
          end else begin
            state <= S_POS;
          end
        end
        S_DIFF: begin
          if (jj == ii) begin
            state <= S_NXTJ;
          end else begin
            dx <= 33'(signed'(b_rdata.pos_x)) - 33'(xi);
            dy <= 33'(signed'(b_rdata.pos_y)) - 33'(yi);
            k  <= 48'(({32'd0, gravity_constant} * {32'd0, b_rdata.mass}) >> 16);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          adx <= dx[32] ? 33'(-dx) : 33'(dx);
          ady <= dy[32] ? 33'(-dy) : 33'(dy);
          state <= S_SQRT;
          sq_cnt <= 6'd0;
          sqv <= '0;
        end
        S_SQRT: begin
          if (sq_cnt == 6'd0) begin
            sqx <= {33'd0, adx} * {33'd0, adx};
            sqy <= {33'd0, ady} * {33'd0, ady};
            sq_cnt <= 6'd1;
          end else if (sq_cnt == 6'd1) begin
            sqv <= 64'((sqx >> 2) + (sqy >> 2));
            sq_rem <= '0; sq_res <= '0;
            sq_cnt <= 6'd2;
          end else begin
            sqv <= {sqv[61:0], 2'b00};
            if (sq_trial >= {32'd0, sq_res, 2'b01}) begin
              sq_rem <= 64'(sq_trial - {32'd0, sq_res, 2'b01});
              sq_res <= {sq_res[30:0], 1'b1};
            end else begin
              sq_rem <= sq_trial[63:0];
              sq_res <= {sq_res[30:0], 1'b0};
            end
            sq_cnt <= sq_cnt + 6'd1;
            if (sq_cnt == 6'd33) begin
              state <= S_FDIV;
            end
          end
        end
        S_FDIV: begin
          if (sq_cnt == 6'd34) begin
            rh <= sq_res;
            if (sq_res == '0) begin
              state <= S_NXTJ;
            end else begin
              d_num <= {2'd0, k, 30'd0};
              d_den <= {32'd0, sq_res} * {32'd0, sq_res};
              div_go <= 1'b1;
              sq_cnt <= 6'd35;
            end
          end else if (d_done) begin
            f <= (d_quot >= 80'(nbg_pkg::F_CAP)) ? nbg_pkg::F_CAP : d_quot[33:0];
            d_num <= {17'd0, adx, 30'd0};
            d_den <= {31'd0, rh, 1'b0};
            div_go <= 1'b1;
            state <= S_UXD;
          end
        end
        S_UXD: begin
          if (d_done) begin
            ux <= d_quot[63:0];
            d_num <= {17'd0, ady, 30'd0};
            div_go <= 1'b1;
            state <= S_UYD;
          end
        end
        S_UYD: begin
          if (d_done) begin
            // |d|/r in Q2.30 stays below 2^31
            prod <= {64'd0, f} * {66'd0, ux[31:0]};
            ux <= d_quot[63:0];
            state <= S_TERM;
            sq_cnt <= 6'd0;
          end
        end
        S_TERM: begin
          if (sq_cnt == 6'd0) begin
            ax <= dx[32] ? ax - 68'(prod >> 30) : ax + 68'(prod >> 30);
            prod <= {64'd0, f} * {66'd0, ux[31:0]};
            sq_cnt <= 6'd1;
          end else begin
            ay <= dy[32] ? ay - 68'(prod >> 30) : ay + 68'(prod >> 30);
            state <= S_NXTJ;
          end
        end
        S_NXTJ: begin
          if (CW'(jj) == n_eff - CW'(1)) begin
            state <= S_VEL;
          end else begin
            jj <= jj + AW'(1);
            state <= S_RDI;
          end
        end
        S_VEL: begin
          sx_sat <= nbg_pkg::sat32(66'(ax));
          sy_sat <= nbg_pkg::sat32(66'(ay));
          state <= S_VEL2;
        end
        S_VEL2: begin
          // v_we pulses here via comb
          ax <= '0; ay <= '0; jj <= '0;
          if (CW'(ii) == n_eff - CW'(1)) begin
            ii <= '0; phase2 <= 1'b1;
          end else begin
            ii <= ii + AW'(1);
          end
          state <= S_RDI;
        end
        S_POS: state <= S_PRD;
        S_PRD: begin
          body_out  <= 3'(ii);
          vel_x_out <= v_rdata[63:32];
          vel_y_out <= v_rdata[31:0];
          pos_x_out <= 32'(nbg_pkg::sat32(66'(signed'(b_rdata.pos_x)) +
                       66'(mulq(v_rdata[63:32], step_size))));
          pos_y_out <= 32'(nbg_pkg::sat32(66'(signed'(b_rdata.pos_y)) +
                       66'(mulq(v_rdata[31:0], step_size))));
          last_body <= (CW'(ii) == n_eff - CW'(1));
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_body) begin
              state <= S_IDLE;
            end else begin
              ii <= ii + AW'(1);
              state <= S_RDI;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic signed [63:0] vx_new, vy_new;
  assign vx_new = nbg_pkg::sat32(66'(vxi) + 66'(mulq(sx_sat[31:0], step_size)));
  assign vy_new = nbg_pkg::sat32(66'(vyi) + 66'(mulq(sy_sat[31:0], step_size)));

  assign in_ready = (state == S_IDLE);

  always_comb begin
    b_we  = 1'b0;
    b_wdata = b_rdata;
    b_addr = ii;
    v_we  = 1'b0;
    v_addr = ii;
    v_wdata = {vx_new[31:0], vy_new[31:0]};
    if (state == S_IDLE) begin
      b_addr = AW'(body_index);
      b_wdata = '{mass: mass_in, pos_x: pos_x_in, pos_y: pos_y_in,
                  vel_x: vel_x_in, vel_y: vel_y_in};
      b_we = in_valid && opcode == nbg_pkg::OP_LOAD && {29'd0, body_index} < MAX_STARS;
    end else if (state == S_RDI && !phase2) begin
      b_addr = ii;
    end else if (state == S_RDJ && !phase2) begin
      b_addr = jj;
    end else if (state == S_VEL2) begin
      v_we = 1'b1;
    end else if (state == S_PRD) begin
      b_we = 1'b1;
      b_wdata.vel_x = v_rdata[63:32];
      b_wdata.vel_y = v_rdata[31:0];
      b_wdata.pos_x = 32'(nbg_pkg::sat32(66'(signed'(b_rdata.pos_x)) +
                      66'(mulq(v_rdata[63:32], step_size))));
      b_wdata.pos_y = 32'(nbg_pkg::sat32(66'(signed'(b_rdata.pos_y)) +
                      66'(mulq(v_rdata[31:0], step_size))));
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(body_out))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) d_start |=> !d_done)
    else $error("divider finished early");

endmodule
